FILE: rtl/eq3b_pkg.sv
// ----------------------------------------------------------------------------
// Three-band equaliser package
// Widths, register map, reset values and the pole saturation helper.
// ----------------------------------------------------------------------------
package eq3b_pkg;

	localparam int SampleW  = 16;
	localparam int PoleW    = 32;
	localparam int FracW    = 16;
	localparam int CoeffW   = 17;
	localparam int GainW    = 16;
	localparam int MulAW    = 34;
	localparam int MulBW    = 18;
	localparam int ProdW    = MulAW + MulBW;
	localparam int AccW     = ProdW + 2;
	localparam int OutShift = 28;
	localparam int NumPoles = 4;
	localparam int DelayLen = 3;
	localparam int AddrW    = 5;
	localparam int DataW    = 32;

	localparam logic [2:0] REG_LOW_COEFF  = 3'd0;
	localparam logic [2:0] REG_HIGH_COEFF = 3'd1;
	localparam logic [2:0] REG_LOW_GAIN   = 3'd2;
	localparam logic [2:0] REG_MID_GAIN   = 3'd3;
	localparam logic [2:0] REG_HIGH_GAIN  = 3'd4;

	localparam logic [CoeffW-1:0] LowCoeffRst  = CoeffW'(8213);
	localparam logic [CoeffW-1:0] HighCoeffRst = CoeffW'(45708);
	localparam logic [GainW-1:0]  GainRst      = GainW'(4096);

	// Sequencer steps
	localparam logic [3:0] STEP_POLE_LAST = 4'd7;
	localparam logic [3:0] STEP_UPD_LAST  = 4'd8;
	localparam logic [3:0] STEP_MAC_LOW   = 4'd9;
	localparam logic [3:0] STEP_MAC_MID   = 4'd10;
	localparam logic [3:0] STEP_MAC_HIGH  = 4'd11;
	localparam logic [3:0] STEP_FINISH    = 4'd12;

	function automatic logic signed [PoleW-1:0] sat_pole(input logic signed [PoleW+4:0] v);
		logic signed [PoleW+4:0] hi_lim;
		logic signed [PoleW+4:0] lo_lim;
		hi_lim = (PoleW+5)'(signed'({1'b0, {(PoleW-1){1'b1}}}));
		lo_lim = (PoleW+5)'(signed'({1'b1, {(PoleW-1){1'b0}}}));
		if (v > hi_lim)
			sat_pole = {1'b0, {(PoleW-1){1'b1}}};
		else if (v < lo_lim)
			sat_pole = {1'b1, {(PoleW-1){1'b0}}};
		else
			sat_pole = v[PoleW-1:0];
	endfunction

endpackage

FILE: rtl/three_band_equalizer_top.sv
// ----------------------------------------------------------------------------
// Three-band equaliser
// Four-pole low and high splits, per-band gain, rounded and saturated sum.
// ----------------------------------------------------------------------------
// Each sample runs through all sequencer steps before its result is ready. A
// new sample is taken whenever the sequencer is idle, even while the previous
// result still waits on the output, but never before the last one is through.
// One signed 34x18 multiplier is shared by the eight pole updates (low and high
// cascades interleaved, each product registered and added into its pole the
// following cycle) and the three band gains; the finishing step rounds and
// saturates. The sequencer holds its last step until the output register is
// free. Coefficients and gains are written over the APB port; the user must
// write them only while no sample is in flight, as the block does not enforce
// it.
module three_band_equalizer_top
	import eq3b_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [15:0]      s_axis_tdata,   // [15:0] sample_in
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [15:0]      m_axis_tdata,   // [15:0] sample_out
	output logic             m_axis_tuser,   // [0] clipped
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic                       state_q;
	logic [3:0]                 step_q;
	logic [CoeffW-1:0]          low_coeff_q, high_coeff_q;
	logic [GainW-1:0]           low_gain_q, mid_gain_q, high_gain_q;
	logic signed [PoleW-1:0]    lo_ring_q [NumPoles];
	logic signed [PoleW-1:0]    hi_ring_q [NumPoles];
	logic signed [SampleW-1:0]  delay_q [DelayLen];
	logic signed [SampleW-1:0]  sample_q;
	logic signed [ProdW-1:0]    prod_q;
	logic signed [AccW-1:0]     acc_q;
	logic                       out_valid_q;
	logic [SampleW-1:0]         sample_out_q;
	logic                       clipped_q;

	logic                       in_fire, cfg_wr, finish;
	logic                       casc_mul, casc_upd;
	logic signed [PoleW-1:0]    x_sel, p_sel, p_upd;
	logic signed [PoleW:0]      diff;
	logic signed [PoleW:0]      band_h, band_m;
	logic signed [PoleW-1:0]    band_d;
	logic signed [MulAW-1:0]    mul_a;
	logic signed [MulBW-1:0]    mul_b;
	logic signed [ProdW-1:0]    mul_p;
	logic signed [PoleW+4:0]    upd_sum;
	logic signed [PoleW-1:0]    pole_new;
	logic signed [AccW-1:0]     total;
	logic signed [AccW-OutShift-1:0] y;
	logic [3:0]                 step_prev;

	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_wr        = psel && penable && pwrite && pready;
	assign pready        = 1'b1;
	assign finish        = (state_q == ST_RUN) && (step_q == STEP_FINISH)
		&& (!out_valid_q || m_axis_tready);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = sample_out_q;
	assign m_axis_tuser  = clipped_q;

	always_comb begin
		unique case (paddr[4:2])
			REG_LOW_COEFF:  prdata = DataW'(low_coeff_q);
			REG_HIGH_COEFF: prdata = DataW'(high_coeff_q);
			REG_LOW_GAIN:   prdata = DataW'(low_gain_q);
			REG_MID_GAIN:   prdata = DataW'(mid_gain_q);
			REG_HIGH_GAIN:  prdata = DataW'(high_gain_q);
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_coeff_q  <= LowCoeffRst;
			high_coeff_q <= HighCoeffRst;
			low_gain_q   <= GainRst;
			mid_gain_q   <= GainRst;
			high_gain_q  <= GainRst;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_LOW_COEFF:  low_coeff_q  <= pwdata[CoeffW-1:0];
				REG_HIGH_COEFF: high_coeff_q <= pwdata[CoeffW-1:0];
				REG_LOW_GAIN:   low_gain_q   <= pwdata[GainW-1:0];
				REG_MID_GAIN:   mid_gain_q   <= pwdata[GainW-1:0];
				REG_HIGH_GAIN:  high_gain_q  <= pwdata[GainW-1:0];
				default: ;
			endcase
		end
	end

	// Shared multiplier operand select
	assign casc_mul = step_q[0];
	assign p_sel    = casc_mul ? hi_ring_q[0] : lo_ring_q[0];
	assign x_sel    = (step_q[2:1] == 2'd0) ? {sample_q, {FracW{1'b0}}}
		: (casc_mul ? hi_ring_q[NumPoles-1] : lo_ring_q[NumPoles-1]);
	assign diff     = (PoleW+1)'(x_sel) - (PoleW+1)'(p_sel);

	assign band_d = {delay_q[DelayLen-1], {FracW{1'b0}}};
	assign band_h = (PoleW+1)'(band_d) - (PoleW+1)'(hi_ring_q[NumPoles-1]);
	assign band_m = (PoleW+1)'(hi_ring_q[NumPoles-1]) - (PoleW+1)'(lo_ring_q[NumPoles-1]);

	always_comb begin
		priority if (step_q <= STEP_POLE_LAST) begin
			mul_a = MulAW'(diff);
			mul_b = MulBW'(signed'({1'b0, casc_mul ? high_coeff_q : low_coeff_q}));
		end else if (step_q == STEP_MAC_LOW) begin
			mul_a = MulAW'(lo_ring_q[NumPoles-1]);
			mul_b = MulBW'(signed'({1'b0, low_gain_q}));
		end else if (step_q == STEP_MAC_MID) begin
			mul_a = MulAW'(band_m);
			mul_b = MulBW'(signed'({1'b0, mid_gain_q}));
		end else begin
			mul_a = MulAW'(band_h);
			mul_b = MulBW'(signed'({1'b0, high_gain_q}));
		end
	end

	assign mul_p = mul_a * mul_b;

	// Pole update from the registered product
	assign step_prev = step_q - 4'd1;
	assign casc_upd  = step_prev[0];
	assign p_upd     = casc_upd ? hi_ring_q[0] : lo_ring_q[0];
	assign upd_sum   = (PoleW+5)'(p_upd) + (PoleW+5)'(signed'(prod_q[ProdW-1:FracW]));
	assign pole_new  = sat_pole(upd_sum);

	// Round half up and saturate
	assign total = acc_q + AccW'(prod_q) + AccW'(signed'({1'b0, 1'b1, {(OutShift-1){1'b0}}}));
	assign y     = total[AccW-1:OutShift];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			for (int i = 0; i < NumPoles; i++) begin
				lo_ring_q[i] <= '0;
				hi_ring_q[i] <= '0;
			end
			for (int i = 0; i < DelayLen; i++)
				delay_q[i] <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (finish)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_RUN;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					if (step_q != STEP_FINISH)
						step_q <= step_q + 4'd1;
					if (step_q != 4'd0 && step_q <= STEP_UPD_LAST) begin
						if (casc_upd) begin
							for (int i = 0; i < NumPoles-1; i++)
								hi_ring_q[i] <= hi_ring_q[i+1];
							hi_ring_q[NumPoles-1] <= pole_new;
						end else begin
							for (int i = 0; i < NumPoles-1; i++)
								lo_ring_q[i] <= lo_ring_q[i+1];
							lo_ring_q[NumPoles-1] <= pole_new;
						end
					end
					if (finish) begin
						state_q <= ST_IDLE;
						for (int i = DelayLen-1; i > 0; i--)
							delay_q[i] <= delay_q[i-1];
						delay_q[0] <= sample_q;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (in_fire)
			sample_q <= s_axis_tdata;
		if (step_q == STEP_MAC_MID)
			acc_q <= AccW'(prod_q);
		else if (step_q == STEP_MAC_HIGH)
			acc_q <= acc_q + AccW'(prod_q);
		if (finish) begin
			if (y > (AccW-OutShift)'(32767)) begin
				sample_out_q <= 16'h7FFF;
				clipped_q    <= 1'b1;
			end else if (y < -(AccW-OutShift)'(32768)) begin
				sample_out_q <= 16'h8000;
				clipped_q    <= 1'b1;
			end else begin
				sample_out_q <= y[SampleW-1:0];
				clipped_q    <= 1'b0;
			end
		end
	end

endmodule
